// File: rtl/vpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types and codes for the variable partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

	localparam int MAX_SEGMENTS_DEF = 16;
	localparam int ADDR_BITS_DEF    = 16;

	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_FREE  = 2'd1;
	localparam logic [1:0] MODE_LOAD  = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_FIT   = 2'd1;
	localparam logic [1:0] ST_NO_JOB   = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;
	localparam logic [1:0] POL_NEXT  = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  job_id;
		logic [15:0] req_size;
		logic [15:0] seg_addr;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] result_addr;
		logic [4:0]  free_segments;
	} result_t;

	typedef struct packed {
		logic latch;
		logic scan;
		logic exec;
		logic merge_hi;
		logic merge_lo;
		logic rover;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic go_merge;
	} ctl_stat_t;

endpackage

// File: rtl/variable_partition_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_partition_allocator
// Address-ordered segment table with first, best, worst and next fit.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. The table is scanned
// one entry per cycle through a single read port, then an execute step; a free
// that finds a segment of its job then takes two merge steps and a rover fixup.
// The result is on result for exactly the one cycle that done is high and
// cannot be held off; busy drops the cycle after. The fit policy must be
// written through cfg_valid/cfg_data only while idle; the block itself does
// not enforce this.
module variable_partition_allocator #(
	parameter int MAX_SEGMENTS = vpa_pkg::MAX_SEGMENTS_DEF,
	parameter int ADDR_BITS    = vpa_pkg::ADDR_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  vpa_pkg::item_t   item,
	output logic             done,
	output vpa_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_data
);

	vpa_pkg::ctl_cmd_t  cmd;
	vpa_pkg::ctl_stat_t stat;

	assign cfg_ready = 1'b1;

	vpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	vpa_dp #(
		.MAXS (MAX_SEGMENTS),
		.AW   (ADDR_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat),
		.result   (result)
	);

endmodule

// File: rtl/vpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_ctrl
// Sequencer: latch, table scan, execute, merge steps, rover fixup, result strobe.
// ----------------------------------------------------------------------------
module vpa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  vpa_pkg::ctl_stat_t stat,
	output vpa_pkg::ctl_cmd_t  cmd,
	output logic               busy,
	output logic               done
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_SCAN = 7'b0000010,
		S_EXEC = 7'b0000100,
		S_MHI  = 7'b0001000,
		S_MLO  = 7'b0010000,
		S_ROV  = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.latch = start;
				if (start) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (stat.scan_done) state_d = S_EXEC;
				else cmd.scan = 1'b1;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.go_merge ? S_MHI : S_DONE;
			end
			S_MHI: begin
				cmd.merge_hi = 1'b1;
				state_d      = S_MLO;
			end
			S_MLO: begin
				cmd.merge_lo = 1'b1;
				state_d      = S_ROV;
			end
			S_ROV: begin
				cmd.rover = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

// File: rtl/vpa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_dp
// Segment table, scan registers, split/merge shifting and result registers.
// ----------------------------------------------------------------------------
module vpa_dp #(
	parameter int MAXS = vpa_pkg::MAX_SEGMENTS_DEF,
	parameter int AW   = vpa_pkg::ADDR_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vpa_pkg::item_t     item,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_data,
	input  vpa_pkg::ctl_cmd_t  cmd,
	output vpa_pkg::ctl_stat_t stat,
	output vpa_pkg::result_t   result
);

	localparam int IW = $clog2(MAXS);
	localparam int CW = $clog2(MAXS + 1);

	logic [AW-1:0]   start_q [MAXS];
	logic [AW-1:0]   len_q   [MAXS];
	logic [7:0]      owner_q [MAXS];
	logic [MAXS-1:0] busy_q;
	logic [CW-1:0]   count_q, free_q;
	logic [AW-1:0]   rover_q;
	logic            rv_q;
	logic [1:0]      policy_q;

	logic [AW-1:0]   n_start [MAXS];
	logic [AW-1:0]   n_len   [MAXS];
	logic [7:0]      n_owner [MAXS];
	logic [MAXS-1:0] n_busy;

	logic [1:0]    mode_q;
	logic [7:0]    job_q;
	logic [AW-1:0] req_q, addr_q;
	logic [CW-1:0] idx_q;
	logic          f_q, f2_q;
	logic [IW-1:0] k_q, k2_q;
	logic [AW-1:0] bl_q, cs_q, cl_q;
	logic [1:0]    status_q;
	logic [AW-1:0] res_q;

	logic [IW-1:0] kf, rd;
	logic [AW-1:0] rs, rl;
	logic [7:0]    ro;
	logic          rb;
	logic          full, found, cand_a, above;
	logic [CW-1:0] load_p;

	logic          ins_en, set_en, clr_en, mrg_en;
	logic [CW-1:0] ins_pos, del_pos;
	logic [AW-1:0] ins_s, ins_l, mrg_l;
	logic          ins_b;
	logic [7:0]    ins_o;
	logic [IW-1:0] mk;

	logic [AW:0]   hi_end, hi_sum, lo_end, lo_sum;
	logic          hi_ok, lo_ok, rov_in;

	assign kf = (mode_q == vpa_pkg::MODE_ALLOC && policy_q == vpa_pkg::POL_NEXT && !f_q)
		? k2_q : k_q;
	assign found  = f_q | f2_q;
	assign full   = (count_q == CW'(MAXS));
	assign load_p = f_q ? CW'(k_q) : count_q;

	always_comb begin
		rd = idx_q[IW-1:0];
		if (cmd.exec) rd = kf;
		else if (cmd.merge_hi) rd = k_q + IW'(1);
		else if (cmd.merge_lo) rd = k_q - IW'(1);
	end

	assign rs = start_q[rd];
	assign rl = len_q[rd];
	assign ro = owner_q[rd];
	assign rb = busy_q[rd];

	assign cand_a = !rb && (rl >= req_q);
	assign above  = !rv_q || (rs >= rover_q);

	assign hi_end = {1'b0, cs_q} + {1'b0, cl_q};
	assign hi_sum = {1'b0, cl_q} + {1'b0, rl};
	assign hi_ok  = ((CW'(k_q) + CW'(1)) < count_q) && !rb && (hi_end == {1'b0, rs}) &&
		!hi_sum[AW];
	assign lo_end = {1'b0, rs} + {1'b0, rl};
	assign lo_sum = {1'b0, rl} + {1'b0, cl_q};
	assign lo_ok  = (k_q != '0) && !rb && (lo_end == {1'b0, cs_q}) && !lo_sum[AW];
	assign rov_in = rv_q && (rover_q >= cs_q) && ({1'b0, rover_q} < hi_end);

	assign stat.scan_done = (idx_q == count_q);
	assign stat.go_merge  = (mode_q == vpa_pkg::MODE_FREE) && f_q;

	always_comb begin
		ins_en  = 1'b0;
		set_en  = 1'b0;
		clr_en  = 1'b0;
		mrg_en  = 1'b0;
		ins_pos = load_p;
		ins_s   = addr_q;
		ins_l   = req_q;
		ins_b   = 1'b0;
		ins_o   = '0;
		del_pos = CW'(k_q) + CW'(1);
		mk      = k_q;
		mrg_l   = hi_sum[AW-1:0];
		if (cmd.exec) begin
			case (mode_q)
				vpa_pkg::MODE_LOAD: ins_en = !full;
				vpa_pkg::MODE_ALLOC: begin
					if (req_q != '0 && found) begin
						if (rl == req_q) begin
							set_en = 1'b1;
						end else if (!full) begin
							set_en  = 1'b1;
							ins_en  = 1'b1;
							ins_pos = CW'(kf) + CW'(1);
							ins_s   = rs + req_q;
							ins_l   = rl - req_q;
						end
					end
				end
				vpa_pkg::MODE_FREE: clr_en = f_q;
				default: ;
			endcase
		end
		if (cmd.merge_hi) mrg_en = hi_ok;
		if (cmd.merge_lo) begin
			mrg_en  = lo_ok;
			del_pos = CW'(k_q);
			mk      = k_q - IW'(1);
			mrg_l   = lo_sum[AW-1:0];
		end
	end

	always_comb begin
		n_start = start_q;
		n_len   = len_q;
		n_owner = owner_q;
		n_busy  = busy_q;
		if (ins_en) begin
			for (int j = 0; j < MAXS; j++) begin
				if (CW'(j) > ins_pos && CW'(j) <= count_q) begin
					n_start[j] = start_q[IW'(j - 1)];
					n_len[j]   = len_q[IW'(j - 1)];
					n_owner[j] = owner_q[IW'(j - 1)];
					n_busy[j]  = busy_q[IW'(j - 1)];
				end else if (CW'(j) == ins_pos) begin
					n_start[j] = ins_s;
					n_len[j]   = ins_l;
					n_owner[j] = ins_o;
					n_busy[j]  = ins_b;
				end
			end
		end
		if (set_en) begin
			n_len[kf]   = req_q;
			n_owner[kf] = job_q;
			n_busy[kf]  = 1'b1;
		end
		if (clr_en) n_busy[kf] = 1'b0;
		if (mrg_en) begin
			for (int j = 0; j < MAXS; j++) begin
				if (CW'(j) >= del_pos && CW'(j) < count_q - CW'(1)) begin
					n_start[j] = start_q[IW'(j + 1)];
					n_len[j]   = len_q[IW'(j + 1)];
					n_owner[j] = owner_q[IW'(j + 1)];
					n_busy[j]  = busy_q[IW'(j + 1)];
				end
			end
			n_len[mk] = mrg_l;
		end
	end

	always_ff @(posedge clk) begin
		start_q <= n_start;
		len_q   <= n_len;
		owner_q <= n_owner;
		if (cmd.latch) begin
			mode_q <= item.mode;
			job_q  <= item.job_id;
			req_q  <= AW'(item.req_size);
			addr_q <= AW'(item.seg_addr);
		end
		if (cmd.scan) begin
			case (mode_q)
				vpa_pkg::MODE_ALLOC: begin
					case (policy_q)
						vpa_pkg::POL_BEST: if (cand_a && (!f_q || rl < bl_q)) begin
							k_q  <= idx_q[IW-1:0];
							bl_q <= rl;
						end
						vpa_pkg::POL_WORST: if (cand_a && (!f_q || rl > bl_q)) begin
							k_q  <= idx_q[IW-1:0];
							bl_q <= rl;
						end
						vpa_pkg::POL_NEXT: begin
							if (cand_a && above && !f_q) k_q <= idx_q[IW-1:0];
							if (cand_a && !above && !f2_q) k2_q <= idx_q[IW-1:0];
						end
						default: if (cand_a && !f_q) k_q <= idx_q[IW-1:0];
					endcase
				end
				vpa_pkg::MODE_FREE: if (rb && ro == job_q && !f_q) k_q <= idx_q[IW-1:0];
				vpa_pkg::MODE_LOAD: if (rs > addr_q && !f_q) k_q <= idx_q[IW-1:0];
				default: ;
			endcase
		end
		if (cmd.exec) begin
			k_q  <= kf;
			cs_q <= rs;
			cl_q <= rl;
			if (set_en) cl_q <= req_q;
			status_q <= vpa_pkg::ST_OK;
			res_q    <= '0;
			case (mode_q)
				vpa_pkg::MODE_LOAD: if (full) status_q <= vpa_pkg::ST_FULL;
				vpa_pkg::MODE_ALLOC: begin
					if (req_q == '0 || !found) status_q <= vpa_pkg::ST_NO_FIT;
					else if (set_en) res_q <= rs;
					else status_q <= vpa_pkg::ST_FULL;
				end
				vpa_pkg::MODE_FREE: begin
					if (f_q) res_q <= rs;
					else status_q <= vpa_pkg::ST_NO_JOB;
				end
				default: ;
			endcase
		end
		if (cmd.merge_hi && hi_ok) cl_q <= hi_sum[AW-1:0];
		if (cmd.merge_lo && lo_ok) begin
			cs_q <= rs;
			cl_q <= lo_sum[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= '0;
			count_q  <= '0;
			free_q   <= '0;
			rover_q  <= '0;
			rv_q     <= 1'b0;
			policy_q <= vpa_pkg::POL_FIRST;
			idx_q    <= '0;
			f_q      <= 1'b0;
			f2_q     <= 1'b0;
		end else begin
			busy_q <= n_busy;
			if (cfg_we) policy_q <= cfg_data;
			if (cmd.latch) begin
				idx_q <= '0;
				f_q   <= 1'b0;
				f2_q  <= 1'b0;
			end
			if (cmd.scan) begin
				idx_q <= idx_q + CW'(1);
				case (mode_q)
					vpa_pkg::MODE_ALLOC: begin
						if (policy_q == vpa_pkg::POL_NEXT) begin
							if (cand_a && above) f_q <= 1'b1;
							if (cand_a && !above) f2_q <= 1'b1;
						end else if (cand_a) begin
							f_q <= 1'b1;
						end
					end
					vpa_pkg::MODE_FREE: if (rb && ro == job_q) f_q <= 1'b1;
					vpa_pkg::MODE_LOAD: if (rs > addr_q) f_q <= 1'b1;
					default: ;
				endcase
			end
			if (ins_en) count_q <= count_q + CW'(1);
			if (mrg_en) begin
				count_q <= count_q - CW'(1);
				free_q  <= free_q - CW'(1);
			end
			if (cmd.exec) begin
				if (mode_q == vpa_pkg::MODE_LOAD && ins_en) free_q <= free_q + CW'(1);
				if (clr_en) free_q <= free_q + CW'(1);
				if (set_en && !ins_en) free_q <= free_q - CW'(1);
				if (set_en) begin
					rover_q <= rs + req_q;
					rv_q    <= 1'b1;
				end
			end
			if (cmd.rover && rov_in) rover_q <= cs_q;
		end
	end

	assign result.status        = status_q;
	assign result.result_addr   = 16'(res_q);
	assign result.free_segments = 5'(free_q);

endmodule

// File: rtl/vpa_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_chk
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module vpa_chk #(
	parameter int MAX_SEGMENTS = vpa_pkg::MAX_SEGMENTS_DEF
) (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input vpa_pkg::result_t result
);

	a_strobe_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done)) else $error("accepted word not busy");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (busy ##1 !busy)) else $error("busy not released after result");

	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(result.free_segments) <= MAX_SEGMENTS))
		else $error("free segment count out of range");

endmodule

bind variable_partition_allocator vpa_chk #(
	.MAX_SEGMENTS (MAX_SEGMENTS)
) u_vpa_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// File: bench/variable_partition_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_partition_allocator_tb
// Drives load, allocate and free words through the start/busy port and checks
// every result against an in-bench segment table under all four fit policies.
// ----------------------------------------------------------------------------
module variable_partition_allocator_tb;

	localparam int NSEG = vpa_pkg::MAX_SEGMENTS_DEF;
	localparam int WDOG_LIMIT = 4000;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	vpa_pkg::item_t item = '0;
	logic done;
	vpa_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_data = vpa_pkg::POL_FIRST;

	variable_partition_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// segment table mirror
	logic [15:0] tb_start [NSEG];
	logic [15:0] tb_len [NSEG];
	logic tb_used [NSEG];
	logic [7:0] tb_owner [NSEG];
	int tb_count;
	logic [15:0] rover;
	logic rover_ok;
	logic [1:0] policy;

	vpa_pkg::item_t pending_words[$];
	vpa_pkg::result_t expected_results[$];
	int errors = 0;
	int idle_cycles = 0;
	logic timed_out = 1'b0;
	int gap_left = 0;
	int burst_left = 0;

	function automatic void add_word(vpa_pkg::item_t w);
		pending_words = {pending_words, w};
	endfunction

	function automatic int free_count();
		int n;
		n = 0;
		for (int i = 0; i < tb_count; i++) if (!tb_used[i]) n++;
		return n;
	endfunction

	function automatic void open_at(int p);
		for (int i = tb_count; i > p; i--) begin
			tb_start[i] = tb_start[i-1]; tb_len[i] = tb_len[i-1];
			tb_used[i] = tb_used[i-1]; tb_owner[i] = tb_owner[i-1];
		end
		tb_count++;
	endfunction

	function automatic void close_at(int p);
		for (int i = p; i < tb_count - 1; i++) begin
			tb_start[i] = tb_start[i+1]; tb_len[i] = tb_len[i+1];
			tb_used[i] = tb_used[i+1]; tb_owner[i] = tb_owner[i+1];
		end
		tb_count--;
	endfunction

	function automatic bit merge_pair(int a);
		if (a + 1 >= tb_count) return 0;
		if (tb_used[a] || tb_used[a+1]) return 0;
		if (17'(tb_start[a]) + 17'(tb_len[a]) != 17'(tb_start[a+1])) return 0;
		if (17'(tb_len[a]) + 17'(tb_len[a+1]) > 17'hFFFF) return 0;
		tb_len[a] = tb_len[a] + tb_len[a+1];
		close_at(a + 1);
		return 1;
	endfunction

	function automatic int pick_segment(logic [15:0] req);
		int best;
		bit above;
		best = tb_count;
		if (policy == vpa_pkg::POL_NEXT) begin
			for (int pass = 0; pass < 2; pass++)
				for (int i = 0; i < tb_count; i++) begin
					above = rover_ok ? (tb_start[i] >= rover) : 1'b1;
					if ((pass == 0) ? !above : above) continue;
					if (!tb_used[i] && tb_len[i] >= req) return i;
				end
			return tb_count;
		end
		for (int i = 0; i < tb_count; i++) begin
			if (tb_used[i] || tb_len[i] < req) continue;
			if (policy == vpa_pkg::POL_FIRST) return i;
			if (best == tb_count) best = i;
			else if (policy == vpa_pkg::POL_BEST && tb_len[i] < tb_len[best]) best = i;
			else if (policy == vpa_pkg::POL_WORST && tb_len[i] > tb_len[best]) best = i;
		end
		return best;
	endfunction

	function automatic vpa_pkg::result_t predict_allocation(vpa_pkg::item_t w);
		vpa_pkg::result_t r;
		int k, p;
		r = '0;
		r.status = vpa_pkg::ST_OK;
		if (w.mode == vpa_pkg::MODE_LOAD) begin
			if (tb_count >= NSEG) r.status = vpa_pkg::ST_FULL;
			else begin
				p = 0;
				while (p < tb_count && tb_start[p] <= w.seg_addr) p++;
				open_at(p);
				tb_start[p] = w.seg_addr; tb_len[p] = w.req_size;
				tb_used[p] = 1'b0; tb_owner[p] = '0;
			end
		end else if (w.mode == vpa_pkg::MODE_ALLOC) begin
			k = (w.req_size == 0) ? tb_count : pick_segment(w.req_size);
			if (k >= tb_count) r.status = vpa_pkg::ST_NO_FIT;
			else if (tb_len[k] == w.req_size) begin
				tb_used[k] = 1'b1; tb_owner[k] = w.job_id; r.result_addr = tb_start[k];
			end else if (tb_count >= NSEG) r.status = vpa_pkg::ST_FULL;
			else begin
				open_at(k + 1);
				tb_start[k+1] = tb_start[k] + w.req_size;
				tb_len[k+1] = tb_len[k] - w.req_size;
				tb_used[k+1] = 1'b0; tb_owner[k+1] = '0;
				tb_len[k] = w.req_size; tb_used[k] = 1'b1; tb_owner[k] = w.job_id;
				r.result_addr = tb_start[k];
			end
			if (r.status == vpa_pkg::ST_OK) begin
				rover = r.result_addr + w.req_size;
				rover_ok = 1'b1;
			end
		end else if (w.mode == vpa_pkg::MODE_FREE) begin
			k = tb_count;
			for (int i = 0; i < tb_count; i++)
				if (tb_used[i] && tb_owner[i] == w.job_id) begin
					k = i;
					break;
				end
			if (k >= tb_count) r.status = vpa_pkg::ST_NO_JOB;
			else begin
				r.result_addr = tb_start[k];
				tb_used[k] = 1'b0; tb_owner[k] = '0;
				void'(merge_pair(k));
				if (k > 0 && merge_pair(k - 1)) k--;
				if (rover_ok && rover >= tb_start[k]
						&& 17'(rover) < 17'(tb_start[k]) + 17'(tb_len[k]))
					rover = tb_start[k];
			end
		end
		r.free_segments = 5'(free_count());
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				expected_results = {expected_results, predict_allocation(item)};
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (pending_words.size() > 0) begin
					item <= pending_words.pop_front();
					start <= 1'b1;
					if (burst_left > 0) burst_left <= burst_left - 1;
					else begin
						burst_left <= $urandom_range(0, 12);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
					end
				end else
					start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		vpa_pkg::result_t e;
		int bad;
		bad = 0;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result: expected none actual %p", $time, result);
				bad++;
			end else begin
				e = expected_results.pop_front();
				if (result.status !== e.status) begin
					$display("%0t status: expected %0d actual %0d", $time, e.status,
						result.status);
					bad++;
				end
				if (result.result_addr !== e.result_addr) begin
					$display("%0t result_addr: expected %h actual %h", $time,
						e.result_addr, result.result_addr);
					bad++;
				end
				if (result.free_segments !== e.free_segments) begin
					$display("%0t free_segments: expected %0d actual %0d", $time,
						e.free_segments, result.free_segments);
					bad++;
				end
			end
		end
		if (bad != 0) errors <= errors + bad;
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT && !timed_out) begin
			timed_out <= 1'b1;
			$display("** variable_partition_allocator: FAILED **");
			$finish;
		end
	end

	function automatic vpa_pkg::item_t make_word(logic [1:0] m, logic [7:0] j,
			logic [15:0] s, logic [15:0] a);
		vpa_pkg::item_t w;
		w.mode = m; w.job_id = j; w.req_size = s; w.seg_addr = a;
		return w;
	endfunction

	task automatic wait_drained();
		while (pending_words.size() > 0 || start || busy || expected_results.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_policy(logic [1:0] p);
		cfg_data <= p;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		policy = p;
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(int n);
		int r, base;
		logic [7:0] job;
		logic [15:0] sz;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			job = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
			if (r < 20) begin
				base = $urandom_range(0, 3) * 16384;
				add_word(make_word(vpa_pkg::MODE_LOAD, 8'($urandom),
					($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600)),
					($urandom_range(0, 9) == 0) ? 16'($urandom)
						: 16'(base + $urandom_range(0, 2000))));
			end else if (r < 60) begin
				sz = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
				add_word(make_word(vpa_pkg::MODE_ALLOC, job, sz, 16'($urandom)));
			end else if (r < 97)
				add_word(make_word(vpa_pkg::MODE_FREE, job, 16'($urandom), 16'($urandom)));
			else
				add_word(make_word(MODE_SPARE, 8'($urandom), 16'($urandom), 16'($urandom)));
		end
	endtask

	initial begin
		tb_count = 0; rover = '0; rover_ok = 1'b0; policy = vpa_pkg::POL_FIRST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: empty table, abutting loads, splits, merges, full table
		add_word(make_word(vpa_pkg::MODE_ALLOC, 8'd1, 16'd4, 16'd0));
		add_word(make_word(vpa_pkg::MODE_FREE, 8'd9, 16'd0, 16'd0));
		add_word(make_word(MODE_SPARE, 8'hFF, 16'hFFFF, 16'hFFFF));
		add_word(make_word(vpa_pkg::MODE_LOAD, 8'd0, 16'd100, 16'd0));
		add_word(make_word(vpa_pkg::MODE_LOAD, 8'd0, 16'd50, 16'd100));
		add_word(make_word(vpa_pkg::MODE_LOAD, 8'hFF, 16'hFFFF, 16'hFFFF));
		add_word(make_word(vpa_pkg::MODE_LOAD, 8'd0, 16'd0, 16'd100));
		add_word(make_word(vpa_pkg::MODE_ALLOC, 8'd1, 16'd0, 16'd0));
		add_word(make_word(vpa_pkg::MODE_ALLOC, 8'd1, 16'd30, 16'd0));
		add_word(make_word(vpa_pkg::MODE_ALLOC, 8'd1, 16'd50, 16'd0));
		add_word(make_word(vpa_pkg::MODE_ALLOC, 8'hFF, 16'd70, 16'd0));
		add_word(make_word(vpa_pkg::MODE_ALLOC, 8'd2, 16'hFFFF, 16'd0));
		add_word(make_word(vpa_pkg::MODE_FREE, 8'd1, 16'd0, 16'd0));
		add_word(make_word(vpa_pkg::MODE_FREE, 8'd1, 16'd0, 16'd0));
		add_word(make_word(vpa_pkg::MODE_FREE, 8'hFF, 16'd0, 16'd0));
		add_word(make_word(vpa_pkg::MODE_ALLOC, 8'd3, 16'd16, 16'd0));
		for (int i = 0; i < 17; i++)
			add_word(make_word(vpa_pkg::MODE_LOAD, 8'd0, 16'd8, 16'(1000 + 8 * i)));
		add_word(make_word(vpa_pkg::MODE_ALLOC, 8'd4, 16'd2, 16'd0));
		add_word(make_word(vpa_pkg::MODE_ALLOC, 8'd4, 16'd8, 16'd0));
		wait_drained();
		for (int ph = 0; ph < 8; ph++) begin
			write_policy((ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3)));
			random_phase(235);
			wait_drained();
		end
		if (errors == 0)
			$display("** variable_partition_allocator: PASSED **");
		else
			$display("** variable_partition_allocator: FAILED **");
		$finish;
	end
endmodule
